>>> sv/psvs_pkg.sv
// Shared types, opcodes and constants of the polyphonic sine voice synthesizer.
package psvs_pkg;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_CHOKE    = 3'd2,
        OP_SET_VOL  = 3'd3,
        OP_VOL_MOD  = 3'd4,
        OP_TICK     = 3'd5,
        OP_END_BLK  = 3'd6,
        OP_NONE     = 3'd7
    } opcode_t;

    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_ENDED   = 2'd1;
    localparam logic [1:0] KIND_DROPPED = 2'd2;

    localparam int MAX_RESULTS = 16;
    localparam logic [31:0] STEP_RESET = 32'd39370534;
    localparam logic signed [17:0] VOLUME_RESET = 18'sd32768;

    // Work list of the shared multiplier, in the order one voice uses it.
    typedef enum logic [3:0] {
        MS_X2, MS_INNER, MS_MID, MS_SIN, MS_GAIN, MS_SCALE, MS_STEP
    } mstep_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_MUL, ST_EMIT, ST_DONE
    } state_t;

    // 2^(s/12) in Q16.
    function automatic logic [16:0] semitone_ratio(input logic [3:0] s);
        logic [16:0] r;
        begin
            unique case (s)
                4'd0:  r = 17'd65536;
                4'd1:  r = 17'd69433;
                4'd2:  r = 17'd73562;
                4'd3:  r = 17'd77936;
                4'd4:  r = 17'd82570;
                4'd5:  r = 17'd87480;
                4'd6:  r = 17'd92682;
                4'd7:  r = 17'd98193;
                4'd8:  r = 17'd104032;
                4'd9:  r = 17'd110218;
                4'd10: r = 17'd116772;
                4'd11: r = 17'd123715;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/psvs_mul.sv
// Shared registered multiplier of the sine, gain and phase step datapath.
module psvs_mul (
    input  logic        clk,
    input  logic [33:0] a,
    input  logic [31:0] b,
    output logic [65:0] p
);
    // Product registered; operands stay below 34 by 32 bits.
    logic [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

>>> sv/polyphonic_sine_voice_synth.sv
// Top level of the polyphonic sine voice synthesizer: voice table, sequencer and mixer.
//
//  Channel   Signals                                             Direction
//  command   start, busy, opcode, note_key, note_ident,          in (busy out)
//            note_channel, amount
//  result    strobe, kind, sample, end_key, end_ident,           out
//            end_channel, last
//  config    cfg_we, cfg_wdata (phase_step_a4)                   in
//
// A command beat is taken when start is high and busy is low. Busy stays high while the
// table is scanned and through the end of scan and done; volume set and the unused code
// skip the walk of the table. A tick gives each held voice a scan step and then the seven
// multiplier steps in turn, each issued and then consumed. End of block holds each ended
// note until the next one is found, and shows the final one at done; the final result
// beat of a command shows in the first cycle with busy low. Reset empties the voice table,
// sets the master volume to one half and the phase step to its default. The receiver
// cannot stall: each result beat lives one cycle on the strobe.
module polyphonic_sine_voice_synth #(
    parameter int VOICES = 16,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic signed [7:0]  note_key,
    input  logic signed [31:0] note_ident,
    input  logic signed [4:0]  note_channel,
    input  logic signed [17:0] amount,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic signed [23:0] sample,
    output logic signed [7:0]  end_key,
    output logic signed [31:0] end_ident,
    output logic signed [4:0]  end_channel,
    output logic               last
);
    import psvs_pkg::*;

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int FB = SINE_TABLE_BITS - 2;

    // Voice table held in flip-flops; each entry is written at a signal-chosen index but
    // read through the single scan pointer only.
    logic              held_reg  [VOICES];
    logic [7:0]        vkey_reg  [VOICES];
    logic [31:0]       vid_reg   [VOICES];
    logic [4:0]        vchan_reg [VOICES];
    logic [31:0]       vphase_reg[VOICES];
    logic signed [17:0] voff_reg [VOICES];

    logic [31:0]        step_a4_reg;
    logic signed [17:0] master_reg;
    logic [CW-1:0]      count_reg;
    state_t             state_reg, state_next;
    mstep_t             ms_reg, ms_next;
    opcode_t            op_reg;
    logic [7:0]         key_reg;
    logic [31:0]        id_reg;
    logic [4:0]         chan_reg;
    logic signed [17:0] amt_reg;
    logic [CW-1:0]      rd_reg, wr_reg;
    logic [4:0]         nres_reg;
    logic               done_mod_reg;
    logic signed [28:0] acc_reg;
    // Ended note waiting to be shown, so that the final one can carry the last flag.
    logic               pend_reg;
    logic [7:0]         pkey_reg;
    logic [31:0]        pid_reg;
    logic [4:0]         pchan_reg;
    // Per-voice sine datapath registers.
    logic [16:0] x_reg, x2_reg, s_reg;
    logic [16:0] gain_reg;
    logic [33:0] mag_reg;
    logic        neg_reg;

    logic [33:0] mul_a;
    logic [31:0] mul_b;
    logic [65:0] mul_p;

    psvs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    logic [IW-1:0] ri, wi;
    assign ri = rd_reg[IW-1:0];
    assign wi = wr_reg[IW-1:0];

    logic hit;
    assign hit = (key_reg == 8'hFF || vkey_reg[ri] == key_reg) &&
                 (id_reg == 32'hFFFFFFFF || vid_reg[ri] == id_reg) &&
                 (chan_reg == 5'h1F || vchan_reg[ri] == chan_reg);
    logic more;
    assign more = rd_reg < count_reg;

    // Phase decomposition for the current voice.
    logic [SINE_TABLE_BITS-1:0] pt;
    logic [1:0]  quad;
    logic [16:0] xf;
    assign pt   = vphase_reg[ri][31 -: SINE_TABLE_BITS];
    assign quad = pt[SINE_TABLE_BITS-1 -: 2];
    assign xf   = 17'({pt[FB-1:0]}) << (16 - FB);

    // Octave and semitone of key - 57, by a small compare chain (range -185..70).
    logic signed [8:0] d;
    logic signed [4:0] oct;
    logic [3:0]        semi;
    always_comb
    begin
        logic signed [9:0] t;
        t    = 10'(signed'(d)) + 10'sd192;   // offset by 16 octaves: always positive
        oct  = '0;
        semi = '0;
        for (int k = 0; k < 24; k++)
        begin
            if (t >= 10'(12 * k) && t < 10'(12 * k + 12))
            begin
                oct  = 5'(k - 16);
                semi = 4'(t - 10'(12 * k));
            end
        end
    end
    assign d = 9'(signed'(vkey_reg[ri])) - 9'sd57;

    // Right shift of the scaled step, 11 to 32 places.
    logic [5:0] sh;
    assign sh = 6'(7'sd16 - 7'(oct));

    // Gain clamp.
    logic signed [18:0] gsum;
    logic [16:0]        gclamp;
    assign gsum = 19'(master_reg) + 19'(voff_reg[ri]);
    assign gclamp = (gsum < 0) ? 17'd0 : (gsum > 19'sd65536) ? 17'd65536 : 17'(gsum);

    logic [16:0] inner;
    assign inner = 17'd42047 - 17'(mul_p[47:16]);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ms_reg)
            MS_X2:    begin mul_a = 34'(x_reg);  mul_b = 32'(x_reg); end
            MS_INNER: begin mul_a = 34'(x2_reg); mul_b = 32'd4640; end
            MS_MID:   begin mul_a = 34'(x2_reg); mul_b = 32'(s_reg); end
            MS_SIN:   begin mul_a = 34'(x_reg);  mul_b = 32'(s_reg); end
            MS_GAIN:  begin mul_a = 34'(s_reg);  mul_b = 32'(gain_reg); end
            MS_SCALE: begin mul_a = mag_reg;     mul_b = 32'd13421773; end
            MS_STEP:  begin mul_a = 34'(step_a4_reg); mul_b = 32'(semitone_ratio(semi)); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Multiplier sequence counter: each step issues on even phase, consumes on odd.
    logic ph_reg;

    always_comb
    begin
        state_next = state_reg;
        ms_next = ms_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SCAN;
            ST_SCAN: if (!more) state_next = ST_DONE;
                     else if (op_reg == OP_TICK && held_reg[ri])
                     begin
                         state_next = ST_MUL;
                         ms_next = MS_X2;
                     end
            ST_MUL:  if (ph_reg && ms_reg == MS_STEP) state_next = ST_SCAN;
                     else if (ph_reg) ms_next = mstep_t'(ms_reg + 4'd1);
            ST_EMIT: state_next = ST_IDLE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ms_reg      <= MS_X2;
            ph_reg      <= 1'b0;
            count_reg   <= '0;
            master_reg  <= VOLUME_RESET;
            step_a4_reg <= STEP_RESET;
            strobe      <= 1'b0;
            kind        <= '0;
            sample      <= '0;
            end_key     <= '0;
            end_ident   <= '0;
            end_channel <= '0;
            last        <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ms_reg    <= ms_next;
            strobe    <= 1'b0;
            if (cfg_we)
                step_a4_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ph_reg <= 1'b0;
                    if (start)
                    begin
                        op_reg   <= opcode_t'(opcode);
                        key_reg  <= note_key;
                        id_reg   <= note_ident;
                        chan_reg <= note_channel;
                        amt_reg  <= amount;
                        rd_reg   <= '0;
                        wr_reg   <= '0;
                        nres_reg <= '0;
                        acc_reg  <= '0;
                        pend_reg <= 1'b0;
                        done_mod_reg <= 1'b0;
                        if (opcode_t'(opcode) == OP_SET_VOL)
                            master_reg <= amount;
                    end
                end
                ST_SCAN:
                begin
                    if (more)
                    begin
                        unique case (op_reg)
                            OP_NOTE_ON, OP_NOTE_OFF:
                            begin
                                if (hit) held_reg[ri] <= 1'b0;
                                rd_reg <= rd_reg + 1'b1;
                            end
                            OP_CHOKE:
                            begin
                                if (!hit)
                                begin
                                    held_reg[wi]   <= held_reg[ri];
                                    vkey_reg[wi]   <= vkey_reg[ri];
                                    vid_reg[wi]    <= vid_reg[ri];
                                    vchan_reg[wi]  <= vchan_reg[ri];
                                    vphase_reg[wi] <= vphase_reg[ri];
                                    voff_reg[wi]   <= voff_reg[ri];
                                    wr_reg <= wr_reg + 1'b1;
                                end
                                rd_reg <= rd_reg + 1'b1;
                            end
                            OP_VOL_MOD:
                            begin
                                if (hit && !done_mod_reg)
                                begin
                                    voff_reg[ri] <= amt_reg;
                                    done_mod_reg <= 1'b1;
                                end
                                rd_reg <= rd_reg + 1'b1;
                            end
                            OP_TICK:
                            begin
                                if (held_reg[ri])
                                begin
                                    x_reg    <= quad[0] ? 17'd65536 - xf : xf;
                                    neg_reg  <= quad[1];
                                    gain_reg <= gclamp;
                                    ph_reg   <= 1'b0;
                                end
                                else
                                    rd_reg <= rd_reg + 1'b1;
                            end
                            OP_END_BLK:
                            begin
                                if (!held_reg[ri] && nres_reg < 5'(MAX_RESULTS))
                                begin
                                    // The previously found note goes out now; this one
                                    // waits, as it may turn out to be the final one.
                                    if (pend_reg)
                                    begin
                                        strobe      <= 1'b1;
                                        kind        <= KIND_ENDED;
                                        sample      <= '0;
                                        end_key     <= pkey_reg;
                                        end_ident   <= pid_reg;
                                        end_channel <= pchan_reg;
                                        last        <= 1'b0;
                                    end
                                    pend_reg  <= 1'b1;
                                    pkey_reg  <= vkey_reg[ri];
                                    pid_reg   <= vid_reg[ri];
                                    pchan_reg <= vchan_reg[ri];
                                    nres_reg  <= nres_reg + 1'b1;
                                end
                                else
                                begin
                                    held_reg[wi]   <= held_reg[ri];
                                    vkey_reg[wi]   <= vkey_reg[ri];
                                    vid_reg[wi]    <= vid_reg[ri];
                                    vchan_reg[wi]  <= vchan_reg[ri];
                                    vphase_reg[wi] <= vphase_reg[ri];
                                    voff_reg[wi]   <= voff_reg[ri];
                                    wr_reg <= wr_reg + 1'b1;
                                end
                                rd_reg <= rd_reg + 1'b1;
                            end
                            default: rd_reg <= count_reg;
                        endcase
                    end
                end
                ST_MUL:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        unique case (ms_reg)
                            MS_X2:    x2_reg <= 17'(mul_p[47:16]);
                            MS_INNER: s_reg  <= inner;
                            MS_MID:   s_reg  <= 17'd102943 - 17'(mul_p[48:16]);
                            MS_SIN:   s_reg  <= (mul_p[49:16] > 34'd65536) ? 17'd65536
                                                : 17'(mul_p[49:16]);
                            MS_GAIN:  mag_reg <= mul_p[33:0];
                            MS_SCALE:
                            begin
                                if (neg_reg)
                                    acc_reg <= acc_reg - 29'((mul_p + 66'd17179869184) >> 35);
                                else
                                    acc_reg <= acc_reg + 29'((mul_p + 66'd17179869184) >> 35);
                            end
                            MS_STEP:
                            begin
                                vphase_reg[ri] <= vphase_reg[ri] + 32'(mul_p >> sh);
                                rd_reg <= rd_reg + 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DONE:
                begin
                    unique case (op_reg)
                        OP_NOTE_ON:
                        begin
                            if (count_reg < CW'(VOICES))
                            begin
                                held_reg[count_reg[IW-1:0]]   <= 1'b1;
                                vkey_reg[count_reg[IW-1:0]]   <= key_reg;
                                vid_reg[count_reg[IW-1:0]]    <= id_reg;
                                vchan_reg[count_reg[IW-1:0]]  <= chan_reg;
                                vphase_reg[count_reg[IW-1:0]] <= '0;
                                voff_reg[count_reg[IW-1:0]]   <= '0;
                                count_reg <= count_reg + 1'b1;
                            end
                            else
                            begin
                                strobe      <= 1'b1;
                                kind        <= KIND_DROPPED;
                                sample      <= '0;
                                end_key     <= key_reg;
                                end_ident   <= id_reg;
                                end_channel <= chan_reg;
                                last        <= 1'b1;
                            end
                        end
                        OP_CHOKE: count_reg <= wr_reg;
                        OP_END_BLK:
                        begin
                            count_reg <= wr_reg;
                            if (pend_reg)
                            begin
                                strobe      <= 1'b1;
                                kind        <= KIND_ENDED;
                                sample      <= '0;
                                end_key     <= pkey_reg;
                                end_ident   <= pid_reg;
                                end_channel <= pchan_reg;
                                last        <= 1'b1;
                            end
                        end
                        OP_TICK:
                        begin
                            strobe      <= 1'b1;
                            kind        <= KIND_SAMPLE;
                            sample      <= (acc_reg > 29'sd8388607) ? 24'sh7FFFFF :
                                           (acc_reg < -29'sd8388608) ? 24'sh800000 :
                                           24'(acc_reg);
                            end_key     <= '0;
                            end_ident   <= '0;
                            end_channel <= '0;
                            last        <= 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(VOICES))
        else $error("voice count beyond table");
    a_idle_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg) == ST_IDLE) |-> !strobe)
        else $error("result while idle");
    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(busy)) |-> $past(start))
        else $error("busy without start");
`endif
endmodule

>>> tb/sv/psvs_checker.sv
// Checker of the polyphonic sine voice synthesizer: voice table predictor and result comparison.
`timescale 1ns / 1ps
module psvs_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         opcode,
    input  logic signed [7:0]  note_key,
    input  logic signed [31:0] note_ident,
    input  logic signed [4:0]  note_channel,
    input  logic signed [17:0] amount,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               strobe,
    input  logic [1:0]         kind,
    input  logic signed [23:0] sample,
    input  logic signed [7:0]  end_key,
    input  logic signed [31:0] end_ident,
    input  logic signed [4:0]  end_channel,
    input  logic               last,
    output int                 errors,
    output int                 pending
);
    import psvs_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] sample;
        logic [7:0]  key;
        logic [31:0] ident;
        logic [4:0]  chan;
        logic        last;
    } synth_out_t;

    typedef struct {
        logic        held;
        logic [7:0]  key;
        logic [31:0] ident;
        logic [4:0]  chan;
        logic [31:0] phase;
        int          offset;
    } voice_t;

    localparam int NV = 16;
    localparam int TBITS = 10;

    synth_out_t expected_beats[$];
    voice_t     voices[$];
    logic [31:0] a4_step;
    int          volume;

    assign pending = expected_beats.size();

    function automatic logic [31:0] key_step(logic [7:0] key);
        int d;
        int oct;
        int semi;
        longint unsigned prod;
        logic [16:0] ratio [12];
        begin
            ratio = '{65536, 69433, 73562, 77936, 82570, 87480,
                      92682, 98193, 104032, 110218, 116772, 123715};
            d = $signed(key) - 57;
            oct = (d >= 0) ? d / 12 : -((-d + 11) / 12);
            semi = d - 12 * oct;
            prod = longint'(a4_step) * longint'(ratio[semi]);
            return 32'(prod >> (16 - oct));
        end
    endfunction

    function automatic int sine_q16(logic [31:0] phase);
        logic [TBITS-1:0] p;
        logic [1:0] q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned inner;
        longint unsigned mid;
        longint unsigned s;
        begin
            p = phase[31 -: TBITS];
            q = p[TBITS-1 -: 2];
            x = longint'(p[TBITS-3:0]) << (16 - (TBITS - 2));
            if (q[0])
                x = 65536 - x;
            x2 = (x * x) >> 16;
            inner = 42047 - ((x2 * 4640) >> 16);
            mid = 102943 - ((x2 * inner) >> 16);
            s = (x * mid) >> 16;
            if (s > 65536)
                s = 65536;
            return q[1] ? -int'(s) : int'(s);
        end
    endfunction

    function automatic bit voice_matches(voice_t v, logic [7:0] k, logic [31:0] id,
                                         logic [4:0] ch);
        return (k == 8'hFF || v.key == k) && (id == 32'hFFFF_FFFF || v.ident == id) &&
               (ch == 5'h1F || v.chan == ch);
    endfunction

    function automatic synth_out_t make_beat(logic [1:0] k, logic [23:0] s, voice_t v);
        synth_out_t b;
        begin
            b.kind = k;
            b.sample = s;
            b.key = v.key;
            b.ident = v.ident;
            b.chan = v.chan;
            b.last = 1'b0;
            return b;
        end
    endfunction

    // Applies one accepted command beat to the voice table and queues its results.
    task automatic predict_command(logic [2:0] op, logic [7:0] k, logic [31:0] id,
                                   logic [4:0] ch, int amt);
        voice_t nv;
        voice_t kept[$];
        synth_out_t beats[$];
        longint acc;
        longint gain;
        longint unsigned mag;
        longint unsigned c;
        int sn;
        begin
            nv = '{1'b1, k, id, ch, 32'd0, 0};
            case (opcode_t'(op))
                OP_NOTE_ON, OP_NOTE_OFF:
                begin
                    foreach (voices[i])
                        if (voice_matches(voices[i], k, id, ch))
                            voices[i].held = 1'b0;
                    if (op == OP_NOTE_ON) begin
                        if (voices.size() < NV)
                            voices.push_back(nv);
                        else
                            beats.push_back(make_beat(KIND_DROPPED, 24'd0, nv));
                    end
                end
                OP_CHOKE:
                begin
                    foreach (voices[i])
                        if (!voice_matches(voices[i], k, id, ch))
                            kept.push_back(voices[i]);
                    voices = kept;
                end
                OP_SET_VOL: volume = amt;
                OP_VOL_MOD:
                begin
                    foreach (voices[i])
                        if (voice_matches(voices[i], k, id, ch)) begin
                            voices[i].offset = amt;
                            break;
                        end
                end
                OP_TICK:
                begin
                    acc = 0;
                    foreach (voices[i]) begin
                        if (!voices[i].held)
                            continue;
                        gain = longint'(volume) + voices[i].offset;
                        if (gain < 0)
                            gain = 0;
                        if (gain > 65536)
                            gain = 65536;
                        sn = sine_q16(voices[i].phase);
                        mag = longint'(sn < 0 ? -sn : sn) * gain;
                        c = (mag * 13421773 + (64'd1 << 34)) >> 35;
                        acc += (sn < 0) ? -longint'(c) : longint'(c);
                        voices[i].phase += key_step(voices[i].key);
                    end
                    if (acc > 8388607)
                        acc = 8388607;
                    if (acc < -8388608)
                        acc = -8388608;
                    nv = '{1'b0, 8'd0, 32'd0, 5'd0, 32'd0, 0};
                    beats.push_back(make_beat(KIND_SAMPLE, 24'(acc), nv));
                end
                OP_END_BLK:
                begin
                    foreach (voices[i]) begin
                        if (!voices[i].held && beats.size() < MAX_RESULTS)
                            beats.push_back(make_beat(KIND_ENDED, 24'd0, voices[i]));
                        else
                            kept.push_back(voices[i]);
                    end
                    voices = kept;
                end
                default: ;
            endcase
            if (beats.size() > 0)
                beats[beats.size() - 1].last = 1'b1;
            foreach (beats[i])
                expected_beats.push_back(beats[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        synth_out_t got;
        synth_out_t want;
        if (!rst_n) begin
            a4_step <= STEP_RESET;
            volume = 32768;
            voices.delete();
            expected_beats.delete();
            errors <= 0;
        end else begin
            // Results are compared before a new command is predicted, since a command
            // accepted at this edge cannot yet have a result on the ports.
            if (strobe) begin
                got = '{kind, sample, end_key, end_ident, end_channel, last};
                if (expected_beats.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result beat %h", got);
                    errors <= errors + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        if (errors < 10)
                            $display("mismatch: kind %0d/%0d sample %0d/%0d key %0d/%0d id %h/%h ch %0d/%0d last %b/%b (exp/got)",
                                     want.kind, got.kind, $signed(want.sample),
                                     $signed(got.sample), $signed(want.key),
                                     $signed(got.key), want.ident, got.ident,
                                     $signed(want.chan), $signed(got.chan),
                                     want.last, got.last);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                predict_command(opcode, note_key, note_ident, note_channel, int'(amount));
            if (cfg_we)
                a4_step <= cfg_wdata;
        end
    end

endmodule

>>> tb/sv/tb_polyphonic_sine_voice_synth.sv
// Testbench top of the polyphonic sine voice synthesizer: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_polyphonic_sine_voice_synth;
    import psvs_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         opcode = OP_NONE;
    logic signed [7:0]  note_key = '0;
    logic signed [31:0] note_ident = '0;
    logic signed [4:0]  note_channel = '0;
    logic signed [17:0] amount = '0;
    logic               cfg_we = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               strobe;
    logic [1:0]         kind;
    logic signed [23:0] sample;
    logic signed [7:0]  end_key;
    logic signed [31:0] end_ident;
    logic signed [4:0]  end_channel;
    logic               last;
    int                 errors;
    int                 pending;

    // Idle gaps are suppressed during one long stretch of the random phase.
    bit quiet;

    always #5 clk = ~clk;

    polyphonic_sine_voice_synth dut (.*);

    psvs_checker u_checker (.*);

    // Drives one command beat and holds it until the block takes it. Start stays high
    // across back-to-back beats, so it is never lowered and raised in one step.
    task automatic send_command(opcode_t op, logic signed [7:0] k, logic signed [31:0] id,
                                logic signed [4:0] ch, logic signed [17:0] amt);
        begin
            if (!quiet && $urandom_range(99) < 11) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            start <= 1'b1;
            opcode <= op;
            note_key <= k;
            note_ident <= id;
            note_channel <= ch;
            amount <= amt;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // Lets the block settle before a register write; a command without results may still
    // be walking the table when the last result has come.
    task automatic wait_idle();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (pending != 0 || busy)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    task automatic write_step(logic [31:0] v);
        begin
            cfg_we <= 1'b1;
            cfg_wdata <= v;
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    // Random key, identifier and channel drawn from a small pool so that matches are common,
    // with occasional wildcards and full-range values.
    task automatic random_note(output logic signed [7:0] k, output logic signed [31:0] id,
                              output logic signed [4:0] ch);
        begin
            k = ($urandom_range(9) == 0) ? -8'sd1 :
                ($urandom_range(3) == 0) ? 8'($urandom_range(127)) :
                8'(50 + $urandom_range(10));
            id = ($urandom_range(9) == 0) ? -32'sd1 :
                 ($urandom_range(3) == 0) ? 32'($urandom) & 32'h7FFF_FFFF :
                 32'($urandom_range(7));
            ch = ($urandom_range(9) == 0) ? -5'sd1 : 5'($urandom_range(15));
        end
    endtask

    task automatic random_phase(int count);
        logic signed [7:0]  k;
        logic signed [31:0] id;
        logic signed [4:0]  ch;
        logic signed [17:0] amt;
        int r;
        begin
            for (int n = 0; n < count; n++) begin
                quiet = (n >= count / 3) && (n < count / 2);
                random_note(k, id, ch);
                amt = 18'($signed($urandom_range(131072)) - 65536);
                r = $urandom_range(99);
                if (r < 28)
                    send_command(OP_NOTE_ON, k, id, ch, amt);
                else if (r < 40)
                    send_command(OP_NOTE_OFF, k, id, ch, amt);
                else if (r < 46)
                    send_command(OP_CHOKE, k, id, ch, amt);
                else if (r < 52)
                    send_command(OP_SET_VOL, k, id, ch, amt);
                else if (r < 60)
                    send_command(OP_VOL_MOD, k, id, ch, amt);
                else if (r < 88)
                    send_command(OP_TICK, k, id, ch, amt);
                else if (r < 97)
                    send_command(OP_END_BLK, k, id, ch, amt);
                else
                    send_command(OP_NONE, k, id, ch, amt);
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset step: extremes of every field, every opcode, a full
        // table with a dropped note, wildcards, volume clamping and a removal pass.
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_NOTE_ON, 8'sd127, 32'sh7FFF_FFFF, 5'sd15, 18'sd65536);
        send_command(OP_NOTE_ON, 8'sd0, 32'sd0, 5'sd0, -18'sd65536);
        send_command(OP_NOTE_ON, 8'sd57, 32'sd5, 5'sd3, 0);
        send_command(OP_VOL_MOD, -8'sd1, -32'sd1, -5'sd1, 18'sd65536);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_SET_VOL, 0, 0, 0, -18'sd65536);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_SET_VOL, 0, 0, 0, 18'sd65536);
        for (int i = 0; i < 14; i++)
            send_command(OP_NOTE_ON, 8'(60 + i), 32'(i), 5'(i), 0);
        send_command(OP_NOTE_ON, -8'sd1, -32'sd1, -5'sd1, 0);
        send_command(OP_TICK, 0, 0, 0, 0);
        send_command(OP_NOTE_OFF, 8'sd57, -32'sd1, -5'sd1, 0);
        send_command(OP_CHOKE, -8'sd1, 32'sd1, -5'sd1, 0);
        send_command(OP_END_BLK, 0, 0, 0, 0);
        send_command(OP_NOTE_OFF, -8'sd1, -32'sd1, -5'sd1, 0);
        send_command(OP_END_BLK, 0, 0, 0, 0);
        send_command(OP_NONE, 0, 0, 0, 0);

        // Random phases, each under another phase step, the extremes among them.
        random_phase(50);
        wait_idle();
        write_step(32'd0);
        random_phase(30);
        wait_idle();
        write_step(32'h8000_0000);
        random_phase(50);
        wait_idle();
        write_step($urandom);
        random_phase(60);

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
